// File: hw/rtl/gf256_dispersal_encoder_macros.svh
// assertion macros for the gf256 dispersal encoder
// the module that uses them must have clk and rst_n in scope
`ifndef GF256_DISPERSAL_ENCODER_MACROS_SVH
`define GF256_DISPERSAL_ENCODER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define GDE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define GDE_ASSERT_NOW(label, ante, cons, msg)
`define GDE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: hw/rtl/gde_pkg.sv
// shared types, constants and the gf(2^8) multiply for the dispersal encoder
// no dependencies
`timescale 1ns / 1ps

package gde_pkg;

    localparam int NUM_ROWS  = 5;
    localparam int GROUP_LEN = 3;
    localparam int BYTE_W    = 8;
    localparam int ROW_W     = GROUP_LEN * BYTE_W;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    // x^8+x^6+x^5+x^4+1
    localparam logic [BYTE_W:0] GF_POLY = 9'h171;

    typedef logic [BYTE_W-1:0] gde_byte_t;
    typedef logic [GROUP_LEN-1:0][BYTE_W-1:0] gde_group_t;
    typedef logic [NUM_ROWS-1:0][BYTE_W-1:0] gde_shares_t;
    typedef logic [NUM_ROWS-1:0][ROW_W-1:0] gde_rows_t;

    typedef enum logic [2:0] {
        REG_ROW0 = 3'd0,
        REG_ROW1 = 3'd1,
        REG_ROW2 = 3'd2,
        REG_ROW3 = 3'd3,
        REG_ROW4 = 3'd4
    } gde_reg_idx_t;

    // default matrix rows built from ascii '1'..'3', row 4 first
    localparam gde_rows_t ROW_RESET = {
        24'h333332, 24'h333232, 24'h313332, 24'h313131, 24'h323331
    };

    // shift-and-add multiply with reduction
    function automatic gde_byte_t gf_mul(input gde_byte_t a, input gde_byte_t b);
        gde_byte_t       acc;
        logic [BYTE_W:0] x;
        acc = '0;
        x   = {1'b0, a};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (b[k])
            begin
                acc = acc ^ x[BYTE_W-1:0];
            end
            x = {x[BYTE_W-1:0], 1'b0};
            if (x[BYTE_W])
            begin
                x = x ^ GF_POLY;
            end
        end
        return acc;
    endfunction

endpackage

// File: hw/rtl/gde_data_if.sv
// stream interface carrying one three-byte data group
// depends on gde_pkg
`timescale 1ns / 1ps

interface gde_data_if;
    logic              valid;
    logic              ready;
    gde_pkg::gde_byte_t data_byte0;
    gde_pkg::gde_byte_t data_byte1;
    gde_pkg::gde_byte_t data_byte2;

    modport source (output valid, output data_byte0, output data_byte1,
                    output data_byte2, input ready);
    modport sink   (input valid, input data_byte0, input data_byte1,
                    input data_byte2, output ready);
endinterface

// File: hw/rtl/gde_share_if.sv
// stream interface carrying the five share bytes of one group
// depends on gde_pkg
`timescale 1ns / 1ps

interface gde_share_if;
    logic              valid;
    logic              ready;
    gde_pkg::gde_byte_t share0;
    gde_pkg::gde_byte_t share1;
    gde_pkg::gde_byte_t share2;
    gde_pkg::gde_byte_t share3;
    gde_pkg::gde_byte_t share4;

    modport source (output valid, output share0, output share1, output share2,
                    output share3, output share4, input ready);
    modport sink   (input valid, input share0, input share1, input share2,
                    input share3, input share4, output ready);
endinterface

// File: hw/rtl/gf256_dispersal_encoder.sv
// gf(2^8) information dispersal encoder: three data bytes in, five share bytes out
// datapath: a group transferred in is held in the input register of gde_core, and its shares
// then in the result register, which drives share_out; back-pressure from share_out can stall both
// throughput: one group per cycle while share_out is ready, set by the two-register datapath in gde_core
// reset: pipeline empties and the coefficient rows load the default '1'..'3' matrix
// depends on gde_pkg, gde_data_if, gde_share_if, gde_regs and gde_core
`timescale 1ns / 1ps

module gf256_dispersal_encoder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gde_pkg::ADDR_W-1:0]  paddr,
    input  logic [gde_pkg::DATA_W-1:0]  pwdata,
    output logic [gde_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    gde_data_if.sink                    data_in,
    gde_share_if.source                 share_out
);

    gde_pkg::gde_rows_t rows;

    gde_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rows    (rows)
    );

    gde_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .rows      (rows),
        .data_in   (data_in),
        .share_out (share_out)
    );

endmodule

// File: hw/rtl/gde_regs.sv
// apb coefficient row registers for the dispersal encoder
// depends on gde_pkg
`timescale 1ns / 1ps

module gde_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gde_pkg::ADDR_W-1:0]  paddr,
    input  logic [gde_pkg::DATA_W-1:0]  pwdata,
    output logic [gde_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output gde_pkg::gde_rows_t          rows
);

    gde_pkg::gde_rows_t    rows_reg;
    gde_pkg::gde_rows_t    rows_next;
    gde_pkg::gde_reg_idx_t reg_idx;
    logic                  wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    // word address, byte offset ignored
    assign reg_idx = gde_pkg::gde_reg_idx_t'(paddr[gde_pkg::ADDR_W-1:2]);

    always_comb
    begin
        rows_next = rows_reg;
        if (wr_en)
        begin
            case (reg_idx)
                gde_pkg::REG_ROW0: rows_next[0] = pwdata[gde_pkg::ROW_W-1:0];
                gde_pkg::REG_ROW1: rows_next[1] = pwdata[gde_pkg::ROW_W-1:0];
                gde_pkg::REG_ROW2: rows_next[2] = pwdata[gde_pkg::ROW_W-1:0];
                gde_pkg::REG_ROW3: rows_next[3] = pwdata[gde_pkg::ROW_W-1:0];
                gde_pkg::REG_ROW4: rows_next[4] = pwdata[gde_pkg::ROW_W-1:0];
                default: rows_next = rows_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            gde_pkg::REG_ROW0: prdata = gde_pkg::DATA_W'(rows_reg[0]);
            gde_pkg::REG_ROW1: prdata = gde_pkg::DATA_W'(rows_reg[1]);
            gde_pkg::REG_ROW2: prdata = gde_pkg::DATA_W'(rows_reg[2]);
            gde_pkg::REG_ROW3: prdata = gde_pkg::DATA_W'(rows_reg[3]);
            gde_pkg::REG_ROW4: prdata = gde_pkg::DATA_W'(rows_reg[4]);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= gde_pkg::ROW_RESET;
        end
        else
        begin
            rows_reg <= rows_next;
        end
    end

    assign rows = rows_reg;

endmodule

// File: hw/rtl/gde_core.sv
// two-stage datapath: input register, gf(2^8) dot products, result register
// depends on gde_pkg, gde_data_if, gde_share_if and the assertion macros
`timescale 1ns / 1ps
`include "gf256_dispersal_encoder_macros.svh"

module gde_core (
    input  logic               clk,
    input  logic               rst_n,
    input  gde_pkg::gde_rows_t rows,
    gde_data_if.sink           data_in,
    gde_share_if.source        share_out
);

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    gde_pkg::gde_group_t  s1_data_reg;
    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    gde_pkg::gde_shares_t s2_share_reg;
    gde_pkg::gde_shares_t share_next;
    logic                 s1_adv;
    logic                 in_xfer;

    // a stage moves on when the one after it is empty or drains this cycle
    assign s1_adv        = !s2_valid_reg || share_out.ready;
    assign data_in.ready = !s1_valid_reg || s1_adv;
    assign in_xfer       = data_in.valid && data_in.ready;

    assign s1_valid_next = in_xfer || (s1_valid_reg && !s1_adv);
    assign s2_valid_next = (s1_valid_reg && s1_adv) || (s2_valid_reg && !share_out.ready);

    always_comb
    begin
        for (int i = 0; i < gde_pkg::NUM_ROWS; i++)
        begin
            share_next[i] = '0;
            for (int j = 0; j < gde_pkg::GROUP_LEN; j++)
            begin
                share_next[i] = share_next[i] ^
                    gde_pkg::gf_mul(rows[i][gde_pkg::BYTE_W*j +: gde_pkg::BYTE_W],
                                    s1_data_reg[j]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_data_reg <= {data_in.data_byte2, data_in.data_byte1, data_in.data_byte0};
        end
        if (s1_valid_reg && s1_adv)
        begin
            s2_share_reg <= share_next;
        end
    end

    assign share_out.valid  = s2_valid_reg;
    assign share_out.share0 = s2_share_reg[0];
    assign share_out.share1 = s2_share_reg[1];
    assign share_out.share2 = s2_share_reg[2];
    assign share_out.share3 = s2_share_reg[3];
    assign share_out.share4 = s2_share_reg[4];

    `GDE_ASSERT_NEXT(a_s1_moves_to_s2, s1_valid_reg && s1_adv, s2_valid_reg, "group lost between stages")
    `GDE_ASSERT_NOW(a_no_take_when_full, s1_valid_reg && !s1_adv, !data_in.ready, "input taken while stage 1 is blocked")
    `GDE_ASSERT_NEXT(a_zero_group, s1_valid_reg && s1_adv && s1_data_reg == '0, s2_share_reg == '0, "zero group gave nonzero share")

endmodule
